/* src/lprd_pkg.sv */
// Shared types and constants for the length-prefixed request deframer.
// No dependencies; every other file imports this package.
package lprd_pkg;

    localparam int MAX_BODY    = 4096;
    localparam int LEN_W       = 13;
    localparam int INDEX_W     = 10;
    localparam int FIELD_BYTES = 4;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 13'd4096;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_CLOSED    = 2'd3
    } status_t;

    // One classified byte as it travels from the front end to the back end.
    typedef struct packed {
        logic               arg_valid;
        logic [7:0]         arg_byte;
        logic [INDEX_W-1:0] arg_index;
        logic               arg_end;
        logic               frame_end;
        status_t            status;
    } evt_t;

endpackage

/* src/lprd_front.sv */
// Front end: accepts stream bytes, assembles 4-byte fields, tracks the
// request framing and classifies each byte. Depends on lprd_pkg.
module lprd_front import lprd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    output logic             push_valid,
    input  logic             push_ready,
    output evt_t             push_data
);

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_COUNT = 2'd1,
        PH_SIZE  = 2'd2,
        PH_DATA  = 2'd3
    } phase_t;

    typedef struct packed {
        logic err;
        logic fend;
        logic to_len;
    } nf_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [23:0]        acc_reg, acc_next;
    logic [LEN_W-1:0]   frame_len_reg, frame_len_next;
    logic [LEN_W-1:0]   frame_pos_reg, frame_pos_next;
    logic [LEN_W-1:0]   args_rem_reg, args_rem_next;
    logic [LEN_W-1:0]   arg_rem_reg, arg_rem_next;
    logic [INDEX_W-1:0] cur_arg_reg, cur_arg_next;
    logic [LEN_W-1:0]   max_len_reg;

    logic               accept;
    logic               field_done;
    logic [31:0]        field_val;
    logic [31:0]        limit;
    logic [LEN_W-1:0]   pos_inc;
    logic [LEN_W-1:0]   remain;
    logic [LEN_W-1:0]   args_left;
    logic [LEN_W-1:0]   data_left;
    nf_t                nf;
    evt_t               evt;

    // Decide what follows once the count or an argument is finished.
    function automatic nf_t next_field(input logic [LEN_W-1:0] left,
                                       input logic [LEN_W-1:0] pos,
                                       input logic [LEN_W-1:0] len,
                                       input logic [LEN_W-1:0] rem);
        nf_t r;
        r = '0;
        if (left == '0) begin
            if (pos != len) begin
                r.err = 1'b1;
            end else begin
                r.fend   = 1'b1;
                r.to_len = 1'b1;
            end
        end else if (rem < LEN_W'(FIELD_BYTES)) begin
            r.err = 1'b1;
        end
        return r;
    endfunction

    assign cfg_ready  = 1'b1;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign push_data  = evt;
    assign accept     = s_valid && push_ready;

    assign field_done = (cnt_reg == 2'd3);
    assign field_val  = {s_data_byte, acc_reg};
    assign limit      = (32'(max_len_reg) > 32'(MAX_BODY)) ? 32'(MAX_BODY)
                                                           : 32'(max_len_reg);
    assign pos_inc    = frame_pos_reg + 1'b1;
    assign remain     = frame_len_reg - pos_inc;
    assign args_left  = args_rem_reg - 1'b1;
    assign data_left  = (arg_rem_reg == '0) ? '0 : arg_rem_reg - 1'b1;

    always_comb begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        frame_len_next = frame_len_reg;
        frame_pos_next = frame_pos_reg;
        args_rem_next  = args_rem_reg;
        arg_rem_next   = arg_rem_reg;
        cur_arg_next   = cur_arg_reg;
        nf             = '0;
        evt            = '0;
        evt.status     = ST_OK;

        // header fields: write the byte into its lane of the little-endian accumulator
        if (phase_reg != PH_DATA) begin
            cnt_next = cnt_reg + 1'b1;
            case (cnt_reg)
                2'd0:    acc_next[7:0]   = s_data_byte;
                2'd1:    acc_next[15:8]  = s_data_byte;
                2'd2:    acc_next[23:16] = s_data_byte;
                default: acc_next        = acc_reg;
            endcase
        end
        if (phase_reg != PH_LEN) begin
            frame_pos_next = pos_inc;
        end

        case (phase_reg)
            PH_LEN: begin
                if (field_done) begin
                    if (field_val > limit) begin
                        evt.status = ST_TOO_LONG;
                    end else if (field_val < 32'(FIELD_BYTES)) begin
                        evt.status = ST_MALFORMED;
                    end else begin
                        frame_len_next = field_val[LEN_W-1:0];
                        frame_pos_next = '0;
                        phase_next     = PH_COUNT;
                    end
                end
            end
            PH_COUNT: begin
                if (field_done) begin
                    if (field_val > limit) begin
                        evt.status = ST_MALFORMED;
                    end else begin
                        args_rem_next = field_val[LEN_W-1:0];
                        cur_arg_next  = '0;
                        nf = next_field(field_val[LEN_W-1:0], pos_inc, frame_len_reg,
                                        remain);
                    end
                end
            end
            PH_SIZE: begin
                if (field_done) begin
                    if (field_val > 32'(remain)) begin
                        evt.status = ST_MALFORMED;
                    end else if (field_val == '0) begin
                        evt.arg_end   = 1'b1;
                        evt.arg_index = cur_arg_reg;
                        args_rem_next = args_left;
                        cur_arg_next  = cur_arg_reg + 1'b1;
                        nf = next_field(args_left, pos_inc, frame_len_reg, remain);
                    end else begin
                        arg_rem_next = field_val[LEN_W-1:0];
                        phase_next   = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                evt.arg_valid = 1'b1;
                evt.arg_byte  = s_data_byte;
                evt.arg_index = cur_arg_reg;
                arg_rem_next  = data_left;
                if (data_left == '0) begin
                    evt.arg_end   = 1'b1;
                    args_rem_next = args_left;
                    cur_arg_next  = cur_arg_reg + 1'b1;
                    nf = next_field(args_left, pos_inc, frame_len_reg, remain);
                end
            end
            default: phase_next = PH_LEN;
        endcase

        // apply the end-of-argument or end-of-count decision
        if (nf.err) begin
            evt.status = ST_MALFORMED;
        end else if (nf.to_len) begin
            evt.frame_end = nf.fend;
            phase_next    = PH_LEN;
            cur_arg_next  = '0;
        end else if ((phase_reg == PH_COUNT && field_done && evt.status == ST_OK) ||
                     (phase_reg == PH_SIZE && field_done && field_val == '0 &&
                      evt.status == ST_OK) ||
                     (phase_reg == PH_DATA && data_left == '0)) begin
            phase_next = PH_SIZE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LEN;
            cnt_reg       <= '0;
            frame_len_reg <= '0;
            frame_pos_reg <= '0;
            args_rem_reg  <= '0;
            arg_rem_reg   <= '0;
            cur_arg_reg   <= '0;
            max_len_reg   <= LIMIT_RESET;
        end else begin
            if (cfg_valid) begin
                max_len_reg <= cfg_data;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                frame_len_reg <= frame_len_next;
                frame_pos_reg <= frame_pos_next;
                args_rem_reg  <= args_rem_next;
                arg_rem_reg   <= arg_rem_next;
                cur_arg_reg   <= cur_arg_next;
            end
        end
    end

    // accumulator is overwritten byte by byte before it is read
    always_ff @(posedge aclk) begin
        if (accept) begin
            acc_reg <= acc_next;
        end
    end

endmodule

/* src/lprd_queue.sv */
// Two-entry queue of classified bytes between the front end and the back end.
// Depends on lprd_pkg for the entry type and depth.
module lprd_queue import lprd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  evt_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output evt_t pop_data
);

    evt_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_then_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> push_ready)
        else $error("queue full right after a pop");

endmodule

/* src/lprd_back.sv */
// Back end: applies error and closed handling to classified bytes and
// holds the result register. Depends on lprd_pkg.
module lprd_back import lprd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  evt_t               in_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_arg_valid,
    output logic [7:0]         m_arg_byte,
    output logic [INDEX_W-1:0] m_arg_index,
    output logic               m_arg_end,
    output logic               m_frame_end,
    output logic [1:0]         m_status
);

    logic  m_valid_reg;
    logic  closed_reg, closed_next;
    evt_t  out_reg, out_next;
    logic  take;

    assign in_ready = !m_valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        out_next    = in_data;
        closed_next = closed_reg;
        if (closed_reg) begin
            out_next        = '0;
            out_next.status = ST_CLOSED;
        end else if (in_data.status != ST_OK) begin
            // error result carries nothing but its code; latch closed
            out_next        = '0;
            out_next.status = in_data.status;
            closed_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            closed_reg  <= 1'b0;
        end else begin
            if (take) begin
                m_valid_reg <= 1'b1;
                closed_reg  <= closed_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= out_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_arg_valid = out_reg.arg_valid;
    assign m_arg_byte  = out_reg.arg_byte;
    assign m_arg_index = out_reg.arg_index;
    assign m_arg_end   = out_reg.arg_end;
    assign m_frame_end = out_reg.frame_end;
    assign m_status    = out_reg.status;

    a_closed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        closed_reg |=> closed_reg)
        else $error("closed flag cleared without reset");

    a_error_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status != ST_OK) |-> closed_reg)
        else $error("error result while not closed");

    a_error_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status != ST_OK) |->
            (!out_reg.arg_valid && !out_reg.arg_end && !out_reg.frame_end))
        else $error("error result carries payload");

endmodule

/* src/length_prefixed_request_deframer_core.sv */
// Length-prefixed request deframer: one result per input byte.
// A result passes the queue entry, then the result register, before it is
// valid at the output.
// Throughput: one byte per cycle while the queue has room, set by the front end's
// per-byte field and counter update; a two-entry queue absorbs output stalls.
// Reset (aresetn low at a clock edge) clears framing state, the closed flag
// and the queue, and sets the length limit to 4096; no clearing pass.
module length_prefixed_request_deframer_core import lprd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LEN_W-1:0]   cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_arg_valid,
    output logic [7:0]         m_arg_byte,
    output logic [INDEX_W-1:0] m_arg_index,
    output logic               m_arg_end,
    output logic               m_frame_end,
    output logic [1:0]         m_status
);

    logic push_valid;
    logic push_ready;
    evt_t push_data;
    logic pop_valid;
    logic pop_ready;
    evt_t pop_data;

    lprd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    lprd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lprd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (pop_valid),
        .in_ready    (pop_ready),
        .in_data     (pop_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_arg_valid (m_arg_valid),
        .m_arg_byte  (m_arg_byte),
        .m_arg_index (m_arg_index),
        .m_arg_end   (m_arg_end),
        .m_frame_end (m_frame_end),
        .m_status    (m_status)
    );

endmodule
